### sv/bfr_pkg.sv
// ----------------------------------------------------------------------------
// bfr_pkg
// Shared types and codes for the bounded FIFO with remove by value.
// ----------------------------------------------------------------------------
package bfr_pkg;

  localparam int BFR_DEPTH = 16;

  localparam int CMD_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;
  localparam int OUT_DATA_W = 40;

  localparam logic [CMD_W-1:0] CMD_ENQ = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REM = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic exec;
    logic scan_step;
    logic shift_step;
    logic commit;
  } bfr_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic op_scan;
    logic hit;
    logic miss;
    logic shift_done;
    logic out_free;
  } bfr_stat_t;

endpackage

### sv/bfr_ctrl.sv
// ----------------------------------------------------------------------------
// bfr_ctrl
// Sequencer: dispatch, scan, shift and result hand-off for one command.
// ----------------------------------------------------------------------------
module bfr_ctrl
  import bfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  bfr_stat_t stat,
  output bfr_ctl_t  ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctl.accept = 1'b1;
          state_nxt  = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.op_scan) begin
          state_nxt = S_SCAN;
        end else begin
          ctl.exec  = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        if (stat.hit) begin
          state_nxt = S_SHIFT;
        end else if (stat.miss) begin
          state_nxt = S_DONE;
        end
      end
      S_SHIFT: begin
        ctl.shift_step = 1'b1;
        if (stat.shift_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register can take the result
        if (stat.out_free) begin
          ctl.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### sv/bfr_dpath.sv
// ----------------------------------------------------------------------------
// bfr_dpath
// Entry memory, scan and shift pointers, count and output register.
// ----------------------------------------------------------------------------
module bfr_dpath
  import bfr_pkg::*;
#(
  parameter int DEPTH = BFR_DEPTH
)(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [VALUE_W-1:0]    in_tdata,
  input  logic [CMD_W-1:0]      in_tuser,
  input  bfr_ctl_t              ctl,
  output bfr_stat_t             stat,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [STATUS_W-1:0]   out_tuser
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [VALUE_W-1:0] mem [DEPTH];

  logic [CMD_W-1:0]    cmd_r;
  logic [VALUE_W-1:0]  key_r;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       p_r;
  logic [AW-1:0]       last_r;
  logic [AW-1:0]       w_r;
  logic                pend_r;
  logic [VALUE_W-1:0]  rd_data_r;
  logic                inc_r, dec_r;
  logic [STATUS_W-1:0] res_status_r;
  logic [VALUE_W-1:0]  res_value_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [VALUE_W-1:0]  out_value_r;
  logic [OCC_W-1:0]    out_occ_r;

  logic op_enq, op_deq, op_rem;
  logic full, p_lt, hit, miss;
  logic mem_we, mem_re;
  logic [AW-1:0]      mem_wa;
  logic [VALUE_W-1:0] mem_wd;

  assign op_enq = (cmd_r == CMD_ENQ);
  assign op_deq = (cmd_r == CMD_DEQ);
  assign op_rem = (cmd_r == CMD_REM);
  assign full   = (count_r == CW'(DEPTH));
  assign p_lt   = (p_r < count_r);
  // dequeue takes the first entry, remove the first one equal to the key
  assign hit    = pend_r & (op_deq | (rd_data_r == key_r));
  assign miss   = ~hit & ~p_lt;

  assign stat.op_scan    = op_deq | op_rem;
  assign stat.hit        = hit;
  assign stat.miss       = miss;
  assign stat.shift_done = ~p_lt & ~pend_r;
  assign stat.out_free   = ~out_valid_r | out_tready;

  assign mem_we = (ctl.exec & op_enq & ~full) | (ctl.shift_step & pend_r);
  assign mem_wa = ctl.exec ? count_r[AW-1:0] : w_r;
  assign mem_wd = ctl.exec ? key_r : rd_data_r;
  assign mem_re = (ctl.scan_step & ~hit & p_lt) | (ctl.shift_step & p_lt);

  always_comb begin
    count_nxt = count_r;
    if (inc_r) begin
      count_nxt = count_r + CW'(1);
    end else if (dec_r) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[p_r[AW-1:0]];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      inc_r       <= 1'b0;
      dec_r       <= 1'b0;
    end else begin
      if (ctl.accept) begin
        pend_r <= 1'b0;
        inc_r  <= 1'b0;
        dec_r  <= 1'b0;
      end
      if (ctl.exec && op_enq && !full) begin
        inc_r <= 1'b1;
      end
      if (ctl.scan_step) begin
        if (hit) begin
          dec_r  <= 1'b1;
          pend_r <= 1'b0;
        end else begin
          pend_r <= p_lt;
        end
      end
      if (ctl.shift_step) begin
        pend_r <= p_lt;
      end
      if (ctl.commit) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_r        <= in_tuser;
      key_r        <= in_tdata;
      p_r          <= '0;
      res_status_r <= ST_OK;
      res_value_r  <= '0;
    end
    if (ctl.exec) begin
      if (!op_enq) begin
        res_status_r <= ST_NOT_FOUND;
      end else if (full) begin
        res_status_r <= ST_FULL;
      end
    end
    if (ctl.scan_step) begin
      if (hit) begin
        res_value_r <= rd_data_r;
        w_r         <= last_r;
        p_r         <= CW'(last_r) + CW'(1);
      end else if (p_lt) begin
        last_r <= p_r[AW-1:0];
        p_r    <= p_r + CW'(1);
      end else begin
        res_status_r <= (op_deq && count_r == '0) ? ST_EMPTY : ST_NOT_FOUND;
      end
    end
    if (ctl.shift_step) begin
      if (p_lt) begin
        p_r <= p_r + CW'(1);
      end
      if (pend_r) begin
        w_r <= w_r + AW'(1);
      end
    end
    if (ctl.commit) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
      out_occ_r    <= OCC_W'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {(OUT_DATA_W - VALUE_W - OCC_W)'(0), out_occ_r, out_value_r};

endmodule

### sv/bounded_fifo_with_remove_by_value_core.sv
// ----------------------------------------------------------------------------
// bounded_fifo_with_remove_by_value_core
// Ordered queue of up to DEPTH 32-bit entries with enqueue, dequeue and
// remove-first-match commands.
// ----------------------------------------------------------------------------
// Usage:
//   Input items carry a command in in_tuser (enqueue, dequeue, remove) and a
//   value in in_tdata. Each item yields exactly one result item: status in
//   out_tuser, removed value and new occupancy in out_tdata.
//   One command is worked at a time. Entries sit in a single-port-read,
//   single-port-write memory with the head at address 0, so dequeue and
//   remove walk the memory one entry per cycle: the scan up to the match,
//   then the move of every later entry one place toward the head.
//   Enqueue and bad codes skip the scan and shift; a dequeue or remove that
//   finds nothing skips the shift. in_tready returns in the same cycle that
//   the result is registered in the output register and out_tvalid rises.
//   The next item is taken once the result sits in the output register,
//   so a stalled receiver holds at most one finished result; a second one
//   waits inside the block and input stays stalled until the first leaves.
//   Reset empties the queue (count to zero); memory contents are not
//   cleared, since only written entries are ever read.
// ----------------------------------------------------------------------------
module bounded_fifo_with_remove_by_value_core
  import bfr_pkg::*;
#(
  parameter int DEPTH = BFR_DEPTH
)(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [VALUE_W-1:0]    in_tdata,   // [31:0] item_value
  input  logic [CMD_W-1:0]      in_tuser,   // [1:0] cmd
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [31:0] result_value, [36:32] occupancy
  output logic [STATUS_W-1:0]   out_tuser   // [1:0] status
);

  bfr_ctl_t  ctl;
  bfr_stat_t stat;

  bfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .ctl       (ctl)
  );

  bfr_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .ctl        (ctl),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
